// ===== rtl/core/tccw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccw_pkg
// Shared types, codes and defaults for the text console character writer.
// ----------------------------------------------------------------------------
package tccw_pkg;

    localparam int P_COLS     = 80;
    localparam int P_ROWS     = 25;
    localparam int P_TAB_STOP = 8;
    localparam int Q_DEPTH    = 2;

    localparam int COL_W  = 7;
    localparam int ROW_W  = 6;
    localparam int HW_W   = 13;
    localparam int CFG_AW = 3;

    localparam logic [ROW_W-1:0] ROW_MAX = 6'd63;

    localparam logic [2:0] CMD_PUT     = 3'd0;
    localparam logic [2:0] CMD_READ    = 3'd1;
    localparam logic [2:0] CMD_SETPOS  = 3'd2;
    localparam logic [2:0] CMD_CLRSCR  = 3'd3;
    localparam logic [2:0] CMD_CLRLINE = 3'd4;

    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_ESC    = 8'h1B;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_DEL    = 8'h7F;

    localparam logic REG_ATTR = 1'b0;
    localparam logic REG_SDIS = 1'b1;

    localparam logic [7:0] ATTR_RST = 8'h07;

    typedef enum logic [3:0] {
        OP_GLYPH,
        OP_BS,
        OP_TAB,
        OP_NL,
        OP_CTRL,
        OP_SWALLOW,
        OP_READ,
        OP_SETPOS,
        OP_CLRSCR,
        OP_CLRLINE,
        OP_NOP
    } t_op;

    typedef struct packed {
        logic [2:0]       cmd;
        logic [7:0]       char_code;
        logic [COL_W-1:0] col;
        logic [4:0]       row;
        logic             move_cursor;
    } t_item;

    typedef struct packed {
        logic [HW_W-1:0]  hw_cursor_offset;
        logic [7:0]       cell_char;
        logic [7:0]       cell_attr;
        logic [COL_W-1:0] cursor_col;
        logic [ROW_W-1:0] cursor_row;
    } t_result;

    typedef struct packed {
        t_op              op;
        logic [7:0]       ch;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             mv;
    } t_qent;

endpackage

// ===== rtl/core/tccw_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccw_front
// Accepts commands, tracks the escape prefix and classifies each item.
// ----------------------------------------------------------------------------
module tccw_front import tccw_pkg::*; #(
    parameter int COLS = P_COLS,
    parameter int ROWS = P_ROWS
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_item i_item,
    input  logic  i_full,
    input  logic  i_init,
    output logic  o_busy,
    output logic  o_push,
    output t_qent o_entry
);

    logic r_esc;
    logic n_esc;
    logic swallow;

    assign o_busy  = i_full | i_init;
    assign o_push  = i_start & ~o_busy;
    assign swallow = r_esc && (i_item.char_code == CH_LBRACK);

    always_comb begin
        o_entry.op  = OP_NOP;
        o_entry.ch  = i_item.char_code;
        o_entry.col = i_item.col;
        o_entry.row = ROW_W'(i_item.row);
        o_entry.mv  = i_item.move_cursor;
        n_esc       = r_esc;
        case (i_item.cmd)
            CMD_PUT: begin
                n_esc = ~swallow && (i_item.char_code == CH_ESC);
                if (swallow) begin
                    o_entry.op = OP_SWALLOW;
                end else begin
                    case (i_item.char_code) inside
                        CH_BS:          o_entry.op = OP_BS;
                        CH_TAB:         o_entry.op = OP_TAB;
                        CH_LF, CH_CR:   o_entry.op = OP_NL;
                        [CH_SPACE:CH_DEL]: o_entry.op = OP_GLYPH;
                        default:        o_entry.op = OP_CTRL;
                    endcase
                end
            end
            CMD_READ: begin
                if (int'(i_item.col) < COLS && int'(i_item.row) < ROWS) begin
                    o_entry.op = OP_READ;
                end
            end
            CMD_SETPOS: begin
                o_entry.op = OP_SETPOS;
                if (int'(i_item.col) > COLS - 1) begin
                    o_entry.col = COL_W'(COLS - 1);
                end
                if (int'(i_item.row) > ROWS - 1) begin
                    o_entry.row = ROW_W'(ROWS - 1);
                end
            end
            CMD_CLRSCR:  o_entry.op = OP_CLRSCR;
            CMD_CLRLINE: o_entry.op = OP_CLRLINE;
            default:     o_entry.op = OP_NOP;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esc <= 1'b0;
        end else if (o_push) begin
            r_esc <= n_esc;
        end
    end

endmodule

// ===== rtl/core/tccw_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccw_queue
// Short FIFO of classified items between the front and back ends.
// ----------------------------------------------------------------------------
module tccw_queue import tccw_pkg::*; #(
    parameter int DEPTH = Q_DEPTH
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_qent i_data,
    input  logic  i_pop,
    output t_qent o_data,
    output logic  o_full,
    output logic  o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_qent          r_buf [DEPTH];
    logic [AW-1:0]  r_wp;
    logic [AW-1:0]  r_rp;
    logic [CW-1:0]  r_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_buf[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + AW'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + AW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + CW'(1);
                2'b01:   r_cnt <= r_cnt - CW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== rtl/core/tccw_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccw_back
// Executes items: cursor state, screen memory, fill and scroll sequencers.
// ----------------------------------------------------------------------------
module tccw_back import tccw_pkg::*; #(
    parameter int COLS     = P_COLS,
    parameter int ROWS     = P_ROWS,
    parameter int TAB_STOP = P_TAB_STOP
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_empty,
    input  t_qent   i_head,
    input  logic [7:0] i_attr,
    input  logic    i_sdis,
    output logic    o_pop,
    output logic    o_init,
    output logic    o_valid,
    output t_result o_result
);

    localparam int TOTAL = COLS * ROWS;
    localparam int AW    = $clog2(TOTAL);
    localparam int CW    = $clog2(TOTAL + 1);

    typedef enum logic [7:0] {
        S_INIT   = 8'b0000_0001,
        S_IDLE   = 8'b0000_0010,
        S_EXEC   = 8'b0000_0100,
        S_COMMIT = 8'b0000_1000,
        S_RDWAIT = 8'b0001_0000,
        S_FILL   = 8'b0010_0000,
        S_MOVE   = 8'b0100_0000,
        S_FLUSH  = 8'b1000_0000
    } t_state;

    t_state           r_state;
    t_qent            r_ent;
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    logic [HW_W-1:0]  r_hw;
    logic [CW-1:0]    r_cnt;
    logic [CW-1:0]    r_last;
    logic [CW-1:0]    r_off;
    logic             r_wen;
    logic [COL_W-1:0] r_wcol;
    logic [ROW_W-1:0] r_wrow;
    logic [15:0]      r_wdata;
    logic             r_put;
    logic             r_puthw;
    logic             r_fill;
    logic             r_fill_all;
    logic             r_isread;
    logic             r_wpend;
    logic             r_wzero;
    logic [AW-1:0]    r_waddr;
    logic [15:0]      r_mem [TOTAL];
    logic [15:0]      r_rdata;
    logic             r_valid;
    t_result          r_res;

    logic [COL_W-1:0] tab_tbl [2**COL_W];
    logic [COL_W-1:0] ex_col;
    logic [ROW_W-1:0] ex_row;
    logic             ex_wen;
    logic [COL_W-1:0] ex_wcol;
    logic [ROW_W-1:0] ex_wrow;
    logic [15:0]      ex_wdata;
    logic             ex_put;
    logic             ex_puthw;
    logic [ROW_W-1:0] row_inc;
    logic [15:0]      blank;

    logic [AW-1:0]    cell_addr;
    logic             scroll;
    logic [ROW_W-1:0] hw_row;
    logic [HW_W-1:0]  hw_val;
    int               shift_rows;
    logic [CW:0]      src;
    logic             src_ok;

    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [15:0]      mem_wdata;
    logic             mem_re;
    logic [AW-1:0]    mem_raddr;

    assign o_pop    = (r_state == S_IDLE) && !i_empty;
    assign o_init   = (r_state == S_INIT);
    assign o_valid  = r_valid;
    assign o_result = r_res;
    assign blank    = {i_attr, CH_SPACE};
    assign row_inc  = (r_row < ROW_MAX) ? r_row + ROW_W'(1) : r_row;

    always_comb begin
        for (int i = 0; i < 2**COL_W; i++) begin
            tab_tbl[i] = ((i / TAB_STOP + 1) * TAB_STOP > COLS - 1) ?
                         COL_W'(COLS - 1) : COL_W'((i / TAB_STOP + 1) * TAB_STOP);
        end
    end

    always_comb begin
        ex_col   = r_col;
        ex_row   = r_row;
        ex_wen   = 1'b0;
        ex_wcol  = r_col;
        ex_wrow  = r_row;
        ex_wdata = blank;
        ex_put   = 1'b1;
        ex_puthw = 1'b1;
        case (r_ent.op)
            OP_GLYPH: begin
                ex_wen   = (r_row < ROW_W'(ROWS));
                ex_wdata = {i_attr, r_ent.ch};
                if (r_col == COL_W'(COLS - 1)) begin
                    ex_col = '0;
                    ex_row = row_inc;
                end else begin
                    ex_col = r_col + COL_W'(1);
                end
            end
            OP_BS: begin
                if (r_col != '0) begin
                    ex_col  = r_col - COL_W'(1);
                    ex_wcol = r_col - COL_W'(1);
                    ex_wen  = (r_row < ROW_W'(ROWS));
                end else if (r_row != '0) begin
                    ex_col  = COL_W'(COLS - 1);
                    ex_row  = r_row - ROW_W'(1);
                    ex_wcol = COL_W'(COLS - 1);
                    ex_wrow = r_row - ROW_W'(1);
                    ex_wen  = (r_row <= ROW_W'(ROWS));
                end
            end
            OP_TAB: ex_col = tab_tbl[r_col];
            OP_NL: begin
                ex_col = '0;
                ex_row = row_inc;
            end
            OP_CTRL: ;
            OP_SWALLOW: begin
                ex_put   = 1'b0;
                ex_puthw = 1'b0;
            end
            OP_READ: begin
                ex_put   = 1'b0;
                ex_puthw = 1'b0;
                ex_wcol  = r_ent.col;
                ex_wrow  = r_ent.row;
            end
            OP_SETPOS: begin
                ex_put   = 1'b0;
                ex_puthw = r_ent.mv;
                ex_col   = r_ent.col;
                ex_row   = r_ent.row;
            end
            OP_CLRSCR: begin
                ex_put   = 1'b0;
                ex_puthw = 1'b0;
                ex_wcol  = '0;
                ex_wrow  = '0;
            end
            OP_CLRLINE: begin
                ex_put   = 1'b0;
                ex_puthw = 1'b0;
                ex_wcol  = '0;
            end
            default: begin
                ex_put   = 1'b0;
                ex_puthw = 1'b0;
            end
        endcase
    end

    always_comb begin
        cell_addr  = AW'(int'(r_wrow) * COLS + int'(r_wcol));
        scroll     = r_put && !i_sdis && (r_row >= ROW_W'(ROWS));
        hw_row     = scroll ? ROW_W'(ROWS - 1) : r_row;
        hw_val     = HW_W'(int'(hw_row) * COLS + int'(r_col));
        shift_rows = (int'(r_row) - ROWS + 1 > ROWS) ? ROWS : int'(r_row) - ROWS + 1;
        src        = (CW + 1)'(r_cnt) + (CW + 1)'(r_off);
        src_ok     = (src < (CW + 1)'(TOTAL));
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = '0;
        mem_re    = 1'b0;
        mem_raddr = '0;
        case (r_state)
            S_INIT: begin
                mem_we    = 1'b1;
                mem_waddr = AW'(r_cnt);
            end
            S_COMMIT: begin
                mem_we    = r_wen;
                mem_waddr = cell_addr;
                mem_wdata = r_wdata;
                mem_re    = r_isread;
                mem_raddr = cell_addr;
            end
            S_FILL: begin
                mem_we    = 1'b1;
                mem_waddr = AW'(r_cnt);
                mem_wdata = r_wdata;
            end
            S_MOVE, S_FLUSH: begin
                mem_we    = r_wpend;
                mem_waddr = r_waddr;
                mem_wdata = r_wzero ? 16'h0000 : r_rdata;
                mem_re    = (r_state == S_MOVE) && src_ok;
                mem_raddr = AW'(src);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_cnt   <= '0;
            r_col   <= '0;
            r_row   <= '0;
            r_hw    <= '0;
            r_valid <= 1'b0;
            r_wpend <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                S_INIT: begin
                    if (r_cnt == CW'(TOTAL - 1)) begin
                        r_cnt   <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_cnt <= r_cnt + CW'(1);
                    end
                end
                S_IDLE: begin
                    if (!i_empty) begin
                        r_ent   <= i_head;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_col      <= ex_col;
                    r_row      <= ex_row;
                    r_wen      <= ex_wen;
                    r_wcol     <= ex_wcol;
                    r_wrow     <= ex_wrow;
                    r_wdata    <= ex_wdata;
                    r_put      <= ex_put;
                    r_puthw    <= ex_puthw;
                    r_isread   <= (r_ent.op == OP_READ);
                    r_fill_all <= (r_ent.op == OP_CLRSCR);
                    r_fill     <= (r_ent.op == OP_CLRSCR) ||
                                  ((r_ent.op == OP_CLRLINE) && (r_row < ROW_W'(ROWS)));
                    r_state    <= S_COMMIT;
                end
                S_COMMIT: begin
                    if (r_isread) begin
                        r_state <= S_RDWAIT;
                    end else if (scroll) begin
                        r_row   <= ROW_W'(ROWS - 1);
                        r_hw    <= hw_val;
                        r_off   <= CW'(shift_rows * COLS);
                        r_cnt   <= '0;
                        r_wpend <= 1'b0;
                        r_state <= S_MOVE;
                    end else if (r_fill) begin
                        r_cnt   <= CW'(cell_addr);
                        r_last  <= r_fill_all ? CW'(TOTAL - 1) :
                                   CW'(cell_addr) + CW'(COLS - 1);
                        r_state <= S_FILL;
                    end else begin
                        if (r_puthw) begin
                            r_hw <= hw_val;
                        end
                        r_valid <= 1'b1;
                        r_res   <= '{hw_cursor_offset: r_puthw ? hw_val : r_hw,
                                     cell_char: 8'h00, cell_attr: 8'h00,
                                     cursor_col: r_col, cursor_row: r_row};
                        r_state <= S_IDLE;
                    end
                end
                S_RDWAIT: begin
                    r_valid <= 1'b1;
                    r_res   <= '{hw_cursor_offset: r_hw, cell_char: r_rdata[7:0],
                                 cell_attr: r_rdata[15:8],
                                 cursor_col: r_col, cursor_row: r_row};
                    r_state <= S_IDLE;
                end
                S_FILL: begin
                    if (r_cnt == r_last) begin
                        r_valid <= 1'b1;
                        r_res   <= '{hw_cursor_offset: r_hw, cell_char: 8'h00,
                                     cell_attr: 8'h00,
                                     cursor_col: r_col, cursor_row: r_row};
                        r_state <= S_IDLE;
                    end else begin
                        r_cnt <= r_cnt + CW'(1);
                    end
                end
                S_MOVE: begin
                    r_wpend <= 1'b1;
                    r_waddr <= AW'(r_cnt);
                    r_wzero <= ~src_ok;
                    if (r_cnt == CW'(TOTAL - 1)) begin
                        r_state <= S_FLUSH;
                    end else begin
                        r_cnt <= r_cnt + CW'(1);
                    end
                end
                S_FLUSH: begin
                    r_wpend <= 1'b0;
                    r_valid <= 1'b1;
                    r_res   <= '{hw_cursor_offset: r_hw, cell_char: 8'h00,
                                 cell_attr: 8'h00,
                                 cursor_col: r_col, cursor_row: r_row};
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== rtl/core/text_console_char_writer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_char_writer_unit
// Text screen writer: cursor, escape handling, clears and scroll over a
// COLS x ROWS cell memory.
//
//   channel   | ports                            | flow
//   ----------+----------------------------------+------------------------------
//   command   | start, busy, i_item              | taken when start & !busy
//   result    | o_valid, o_result                | one cycle strobe, no stall
//   config    | psel/penable/pwrite/paddr/pwdata | APB, pready tied high
//
// The back end handles one item at a time (pop from the queue, decode, commit
// through the single memory write port); a cell read adds a wait state for the
// registered read port. Clear line walks the COLS cells of its row, clear
// screen all COLS*ROWS cells and a scroll moves every cell, one cell a cycle.
// A two-entry queue lets commands queue while the back end works; busy rises
// when it is full. After reset the memory is zeroed cell by cell with busy high.
// ----------------------------------------------------------------------------
module text_console_char_writer_unit import tccw_pkg::*; #(
    parameter int COLS        = P_COLS,
    parameter int ROWS        = P_ROWS,
    parameter int TAB_STOP    = P_TAB_STOP,
    parameter int QUEUE_DEPTH = Q_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  t_item             i_item,
    output logic              o_valid,
    output t_result           o_result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [7:0] r_attr;
    logic       r_sdis;
    logic       push;
    logic       pop;
    logic       full;
    logic       empty;
    logic       init;
    t_qent      q_in;
    t_qent      q_out;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr <= ATTR_RST;
            r_sdis <= 1'b0;
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                REG_ATTR: r_attr <= pwdata[7:0];
                REG_SDIS: r_sdis <= pwdata[0];
                default:  ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_ATTR: prdata = {24'h000000, r_attr};
            REG_SDIS: prdata = {31'h00000000, r_sdis};
            default:  prdata = '0;
        endcase
    end

    tccw_front #(
        .COLS (COLS),
        .ROWS (ROWS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_item  (i_item),
        .i_full  (full),
        .i_init  (init),
        .o_busy  (busy),
        .o_push  (push),
        .o_entry (q_in)
    );

    tccw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (q_in),
        .i_pop   (pop),
        .o_data  (q_out),
        .o_full  (full),
        .o_empty (empty)
    );

    tccw_back #(
        .COLS     (COLS),
        .ROWS     (ROWS),
        .TAB_STOP (TAB_STOP)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (empty),
        .i_head   (q_out),
        .i_attr   (r_attr),
        .i_sdis   (r_sdis),
        .o_pop    (pop),
        .o_init   (init),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

endmodule

// ===== tb/tccw_result_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccw_result_checker
// Watches the command, result and register channels of the console writer.
// Keeps its own copy of the screen, cursor, escape flag and hardware cursor,
// works out the expected result of every accepted item and compares each
// result strobe against the oldest outstanding expectation, field by field.
// ----------------------------------------------------------------------------
module tccw_result_checker import tccw_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_busy,
    input  t_item             i_item,
    input  logic              i_valid,
    input  t_result           i_result,
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic [CFG_AW-1:0] i_paddr,
    input  logic [31:0]       i_pwdata,
    input  logic              i_pready,
    output int                o_fail_count,
    output int                o_outstanding,
    output int                o_checked
);

    localparam int CELLS = P_COLS * P_ROWS;

    logic [15:0]     cells [CELLS];
    int unsigned     cur_x;
    int unsigned     cur_y;
    bit              esc_seen;
    logic [HW_W-1:0] hw_pos;
    logic [7:0]      attr;
    bit              scroll_lock;

    t_result         console_status_q[$];
    int              fails   = 0;
    int              checked = 0;

    function automatic void report(string msg);
        fails++;
        $error("%s", msg);
    endfunction

    function automatic void compare_field(string name, int unsigned e, int unsigned a);
        if (e != a) begin
            report($sformatf("%s mismatch: expected %0d, got %0d", name, e, a));
        end
    endfunction

    function automatic void store(int unsigned x, int unsigned y, logic [15:0] v);
        if (x < P_COLS && y < P_ROWS) begin
            cells[y * P_COLS + x] = v;
        end
    endfunction

    function automatic void line_down();
        if (cur_y < ROW_MAX) begin
            cur_y++;
        end
    endfunction

    function automatic void load_hw();
        hw_pos = HW_W'(cur_x + cur_y * P_COLS);
    endfunction

    function automatic void blank_row(int unsigned y);
        if (y >= P_ROWS) begin
            return;
        end
        for (int i = 0; i < P_COLS; i++) begin
            cells[y * P_COLS + i] = {attr, CH_SPACE};
        end
    endfunction

    // shift up by however far the cursor ran off the bottom, zero-fill the rest
    function automatic void scroll_if_needed();
        int unsigned n;
        if (scroll_lock || cur_y < P_ROWS) begin
            return;
        end
        n = cur_y - P_ROWS + 1;
        if (n > P_ROWS) begin
            n = P_ROWS;
        end
        for (int i = 0; i < (P_ROWS - n) * P_COLS; i++) begin
            cells[i] = cells[i + n * P_COLS];
        end
        for (int i = (P_ROWS - n) * P_COLS; i < CELLS; i++) begin
            cells[i] = '0;
        end
        cur_y = P_ROWS - 1;
    endfunction

    function automatic void put_char(logic [7:0] c);
        int unsigned t;
        if (esc_seen) begin
            esc_seen = 1'b0;
            if (c == CH_LBRACK) begin
                return;
            end
        end
        if (c == CH_ESC) begin
            esc_seen = 1'b1;
        end else if (c == CH_BS) begin
            if (cur_x > 0) begin
                cur_x--;
                store(cur_x, cur_y, {attr, CH_SPACE});
            end else if (cur_y > 0) begin
                cur_y--;
                cur_x = P_COLS - 1;
                store(cur_x, cur_y, {attr, CH_SPACE});
            end
        end else if (c == CH_TAB) begin
            t = (cur_x / P_TAB_STOP + 1) * P_TAB_STOP;
            cur_x = (t > P_COLS - 1) ? P_COLS - 1 : t;
        end else if (c == CH_LF || c == CH_CR) begin
            cur_x = 0;
            line_down();
        end else if (c >= CH_SPACE && c <= CH_DEL) begin
            store(cur_x, cur_y, {attr, c});
            cur_x++;
            if (cur_x >= P_COLS) begin
                cur_x = 0;
                line_down();
            end
        end
        scroll_if_needed();
        load_hw();
    endfunction

    function automatic t_result console_step(t_item it);
        t_result r;
        r = '0;
        case (it.cmd)
            CMD_PUT: put_char(it.char_code);
            CMD_READ: begin
                if (it.col < P_COLS && it.row < P_ROWS) begin
                    {r.cell_attr, r.cell_char} = cells[int'(it.row) * P_COLS + int'(it.col)];
                end
            end
            CMD_SETPOS: begin
                cur_x = (it.col > P_COLS - 1) ? P_COLS - 1 : it.col;
                cur_y = (it.row > P_ROWS - 1) ? P_ROWS - 1 : it.row;
                if (it.move_cursor) begin
                    load_hw();
                end
            end
            CMD_CLRSCR: begin
                for (int y = 0; y < P_ROWS; y++) begin
                    blank_row(y);
                end
            end
            CMD_CLRLINE: blank_row(cur_y);
            default: ;
        endcase
        r.hw_cursor_offset = hw_pos;
        r.cursor_col       = COL_W'(cur_x);
        r.cursor_row       = ROW_W'(cur_y);
        return r;
    endfunction

    function automatic void check_result(t_result got);
        t_result exp;
        if (console_status_q.size() == 0) begin
            report("result strobe with no item outstanding");
            return;
        end
        exp = console_status_q.pop_front();
        checked++;
        compare_field("hw_cursor_offset", exp.hw_cursor_offset, got.hw_cursor_offset);
        compare_field("cell_char", exp.cell_char, got.cell_char);
        compare_field("cell_attr", exp.cell_attr, got.cell_attr);
        compare_field("cursor_col", exp.cursor_col, got.cursor_col);
        compare_field("cursor_row", exp.cursor_row, got.cursor_row);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (cells[i]) cells[i] = '0;
            cur_x       = 0;
            cur_y       = 0;
            esc_seen    = 1'b0;
            hw_pos      = '0;
            attr        = ATTR_RST;
            scroll_lock = 1'b0;
            console_status_q.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[CFG_AW-1:2])
                    REG_ATTR: attr = i_pwdata[7:0];
                    REG_SDIS: scroll_lock = i_pwdata[0];
                    default: ;
                endcase
            end
            if (i_valid) begin
                check_result(i_result);
            end
            if (i_start && !i_busy) begin
                console_status_q.push_back(console_step(i_item));
            end
        end
        o_fail_count  <= fails;
        o_outstanding <= console_status_q.size();
        o_checked     <= checked;
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the text console character writer. A directed
// pass covers cursor edges, control bytes, escapes, clears and out-of-range
// cells; random phases then stream text, line breaks, escapes and cursor
// moves under several attribute and scroll settings with varied idling.
// Checking is left to tccw_result_checker.
// ----------------------------------------------------------------------------
module testbench;
    import tccw_pkg::*;

    localparam int  CYCLE_LIMIT  = 20_000_000;
    localparam int  SETTLE_WAIT  = P_COLS * P_ROWS + 100;
    localparam int  PHASE_ITEMS  = 615;

    logic              i_clk;
    logic              i_rst_n = 1'b0;
    logic              start   = 1'b0;
    logic              busy;
    t_item             i_item  = '0;
    logic              o_valid;
    t_result           o_result;
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [CFG_AW-1:0] paddr   = '0;
    logic [31:0]       pwdata  = '0;
    logic [31:0]       prdata;
    logic              pready;

    int fail_count;
    int outstanding;
    int checked;
    int cycle_count = 0;
    int sent        = 0;
    int idle_pct    = 0;

    text_console_char_writer_unit u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_valid  (o_valid),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    tccw_result_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_busy        (busy),
        .i_item        (i_item),
        .i_valid       (o_valid),
        .i_result      (o_result),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .i_pready      (pready),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding),
        .o_checked     (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic t_item cmd_item(logic [2:0] op, logic [7:0] ch,
                                       logic [COL_W-1:0] x, logic [4:0] y, logic mv);
        t_item it;
        it.cmd         = op;
        it.char_code   = ch;
        it.col         = x;
        it.row         = y;
        it.move_cursor = mv;
        return it;
    endfunction

    // all tasks start just after a rising edge
    task automatic issue(input t_item it);
        sent++;
        while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic put_byte(input logic [7:0] c);
        issue(cmd_item(CMD_PUT, c, COL_W'($urandom_range(0, 127)),
                       5'($urandom_range(0, 31)), 1'($urandom_range(0, 1))));
    endtask

    task automatic simple_cmd(input logic [2:0] op);
        issue(cmd_item(op, 8'($urandom_range(0, 255)), COL_W'($urandom_range(0, 127)),
                       5'($urandom_range(0, 31)), 1'($urandom_range(0, 1))));
    endtask

    task automatic cfg_write(input logic idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_AW'({idx, 2'b00});
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // drain, then let clears or a scroll finish before touching registers
    task automatic settle();
        start <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
        repeat (SETTLE_WAIT) @(posedge i_clk);
    endtask

    task automatic random_chunk(input bit scroll_off);
        int               kind;
        logic [COL_W-1:0] x;
        logic [4:0]       y;
        kind = $urandom_range(0, 99);
        if (kind < 40) begin
            repeat ($urandom_range(1, 40)) begin
                if ($urandom_range(0, 9) == 0) begin
                    put_byte($urandom_range(0, 1) ? CH_TAB : CH_BS);
                end else begin
                    put_byte(8'($urandom_range(CH_SPACE, CH_DEL)));
                end
            end
        end else if (kind < 48) begin
            repeat (scroll_off ? $urandom_range(1, 20) : $urandom_range(1, 3)) begin
                put_byte($urandom_range(0, 1) ? CH_CR : CH_LF);
            end
        end else if (kind < 55) begin
            put_byte(CH_ESC);
            put_byte($urandom_range(0, 2) != 0 ? CH_LBRACK : 8'($urandom_range(0, 255)));
        end else if (kind < 61) begin
            repeat ($urandom_range(1, 6)) put_byte(CH_BS);
        end else if (kind < 66) begin
            repeat ($urandom_range(1, 4)) put_byte(CH_TAB);
        end else if (kind < 76) begin
            x = ($urandom_range(0, 3) == 0) ? COL_W'($urandom_range(0, 127))
                                            : COL_W'($urandom_range(0, P_COLS - 1));
            y = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(18, 31))
                                            : 5'($urandom_range(0, 31));
            issue(cmd_item(CMD_SETPOS, 8'($urandom_range(0, 255)), x, y,
                           1'($urandom_range(0, 1))));
            put_byte(8'($urandom_range(CH_SPACE, CH_DEL)));
            issue(cmd_item(CMD_READ, 8'($urandom_range(0, 255)), x, y, 1'b0));
        end else if (kind < 86) begin
            if ($urandom_range(0, 4) == 0) begin
                simple_cmd(CMD_READ);
            end else begin
                issue(cmd_item(CMD_READ, 8'($urandom_range(0, 255)),
                               COL_W'($urandom_range(0, P_COLS - 1)),
                               5'($urandom_range(0, P_ROWS - 1)), 1'($urandom_range(0, 1))));
            end
        end else if (kind < 92) begin
            simple_cmd(CMD_CLRLINE);
        end else if (kind < 94) begin
            simple_cmd(CMD_CLRSCR);
        end else if (kind < 97) begin
            simple_cmd(3'($urandom_range(0, 7)));
        end else begin
            put_byte(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic random_phase(input int quota, input bit scroll_off);
        int stop_at;
        stop_at = sent + quota;
        while (sent < stop_at) random_chunk(scroll_off);
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        cfg_write(REG_ATTR, 32'h0000_001F);
        cfg_write(REG_SDIS, 32'h0);
        idle_pct = 6;

        issue(cmd_item(CMD_READ, 8'h00, '0, '0, 1'b0));
        for (int k = CMD_CLRLINE + 1; k < 8; k++) simple_cmd(3'(k));
        issue(cmd_item(CMD_SETPOS, 8'hFF, '1, '1, 1'b1));
        put_byte("A");                               // wraps off the last row, scrolls
        issue(cmd_item(CMD_READ, 8'h00, COL_W'(P_COLS - 1), 5'(P_ROWS - 2), 1'b0));
        put_byte(CH_BS);                             // column 0: back onto previous row
        issue(cmd_item(CMD_SETPOS, 8'h00, '0, '0, 1'b0));
        put_byte(CH_BS);                             // home: no effect
        put_byte(CH_TAB);
        issue(cmd_item(CMD_SETPOS, 8'h00, COL_W'(P_COLS - 5), 5'd3, 1'b1));
        put_byte(CH_TAB);                            // saturates at the last column
        put_byte(CH_TAB);
        put_byte(CH_ESC);
        put_byte(CH_LBRACK);
        put_byte(CH_ESC);
        put_byte("B");
        put_byte(CH_ESC);
        put_byte(CH_ESC);
        put_byte(CH_LBRACK);
        put_byte(CH_CR);
        put_byte(CH_LF);
        put_byte(8'h00);
        put_byte(8'hFF);
        put_byte(8'h80);
        put_byte(CH_DEL);
        simple_cmd(CMD_CLRLINE);
        simple_cmd(CMD_CLRSCR);
        issue(cmd_item(CMD_READ, 8'h00, '1, '1, 1'b0));
        issue(cmd_item(CMD_READ, 8'h00, COL_W'(P_COLS - 1), 5'(P_ROWS - 1), 1'b0));
        settle();

        cfg_write(REG_ATTR, 32'h0000_00FF);
        cfg_write(REG_SDIS, 32'h0);
        idle_pct = 6;
        random_phase(PHASE_ITEMS, 1'b0);
        settle();

        cfg_write(REG_ATTR, 32'h0);
        cfg_write(REG_SDIS, 32'h1);
        idle_pct = 79;
        random_phase(PHASE_ITEMS, 1'b1);
        repeat (int'(ROW_MAX) + 1) put_byte(CH_LF);  // run the cursor to the row ceiling
        settle();

        cfg_write(REG_ATTR, $urandom);
        cfg_write(REG_SDIS, 32'h0);
        idle_pct = 0;
        random_phase(PHASE_ITEMS, 1'b0);
        settle();

        $display("Ran %0d commands: directed edge cases, then text, escapes and cursor moves",
                 sent);
        $display("with scrolling on and off over four attribute settings; %0d results checked.",
                 checked);
        if (fail_count == 0 && outstanding == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/tccw_pkg.sv
rtl/core/tccw_front.sv
rtl/core/tccw_queue.sv
rtl/core/tccw_back.sv
rtl/core/text_console_char_writer_unit.sv
tb/tccw_result_checker.sv
tb/testbench.sv
